### rtl/core/assert_macros.svh
// Assertion macros shared by the projection profile counter RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a property on every clock edge outside reset
`define PPC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// check that a condition implies another in the same cycle
`define PPC_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// check that a condition implies another in the next cycle
`define PPC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/ppc_pkg.sv
// Types, constants and codes of the projection profile counter
package ppc_pkg;

  localparam int MAX_COLS_DEF = 1024;
  localparam int MAX_ROWS_DEF = 1024;

  localparam int OPCODE_W = 2;
  localparam int PIXEL_W  = 8;
  localparam int INDEX_W  = 10;
  localparam int COUNT_W  = 11;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 11;
  localparam int QDEPTH   = 3;

  localparam logic [OPCODE_W-1:0] OP_PIXEL = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_READ  = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_CLEAR = 2'd2;

  localparam logic KIND_ROW = 1'b0;
  localparam logic KIND_COL = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_MATCH_VALUE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_WIDTH   = 1'd1;

  localparam logic [PIXEL_W-1:0]    MATCH_RST = 8'd255;
  localparam logic [CFG_DATA_W-1:0] WIDTH_RST = 11'd1024;

  typedef struct packed {
    logic [OPCODE_W-1:0] opcode;
    logic [PIXEL_W-1:0]  pixel;
    logic [INDEX_W-1:0]  column_index;
  } in_word_t;

  typedef struct packed {
    logic                kind;
    logic [INDEX_W-1:0]  index;
    logic [COUNT_W-1:0]  count;
  } out_word_t;

  typedef struct packed {
    logic vld;
    logic pix;
    logic res;
    logic kind;
    logic col_vld;
    logic hit;
  } stage_t;

endpackage

### rtl/core/projection_profile_counter_core.sv
// Top level of the projection profile counter: update stage, memory and result queue
//
// Input words arrive on in_valid_i/in_ready_o with an opcode: a pixel of a
// thresholded image in raster order, a column count read, or a clear that
// starts a new frame. Pixels equal to match_value are counted per row and per
// column; the pixel that ends a row yields a row word, a read yields a column
// word, and the other items yield nothing. Results leave on
// out_valid_o/out_ready_i in input order.
// Registers match_value (index 0) and row_width (index 1) are to be written on the
// cfg port only while the block is idle; the block itself does not enforce it.
// One word is taken per cycle while in_ready_o is high. The column memory is read
// at the accepting edge and the next cycle does the read-modify-write and the push
// into a three-word output queue, whose registers hold the result until it leaves.
// Back to back column updates are forwarded.
// A stalled receiver fills the queue; in_ready_o drops once the queue and the
// update stage together hold three results, and rises as words drain.
// Reset restores the registers, empties the queue and marks every column as
// unwritten through a fill mark, so no clearing pass is run and the block
// takes words as soon as reset is released.
`include "assert_macros.svh"

module projection_profile_counter_core import ppc_pkg::*; #(
  parameter int MAX_COLS = MAX_COLS_DEF,
  parameter int MAX_ROWS = MAX_ROWS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  in_word_t              in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output out_word_t             out_data_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  localparam int AW  = $clog2(MAX_COLS);
  localparam int CCW = $clog2(MAX_ROWS + 1);

  logic               fire;
  logic               re;
  logic [AW-1:0]      raddr;
  stage_t             st;
  logic [INDEX_W-1:0] st_idx;
  logic [COUNT_W-1:0] st_cnt;
  logic [AW-1:0]      st_addr;
  logic [CCW-1:0]     rdata;
  logic [CCW-1:0]     old_cnt;
  logic [CCW-1:0]     new_cnt;
  logic               we;
  logic               push;
  out_word_t          push_data;
  logic [1:0]         q_cnt;
  logic               pop;
  logic               rd_fire;

  assign fire = in_valid_i && in_ready_o;

  ppc_frame_ctrl #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_frame_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .fire_i      (fire),
    .in_data_i   (in_data_i),
    .re_o        (re),
    .raddr_o     (raddr),
    .st_o        (st),
    .st_idx_o    (st_idx),
    .st_cnt_o    (st_cnt),
    .st_addr_o   (st_addr)
  );

  ppc_col_mem #(
    .DEPTH (MAX_COLS),
    .DW    (CCW)
  ) u_col_mem (
    .clk_i   (clk_i),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata),
    .we_i    (we),
    .waddr_i (st_addr),
    .wdata_i (new_cnt)
  );

  always_comb begin
    old_cnt = st.col_vld ? rdata : '0;
    new_cnt = (st.hit && (old_cnt < CCW'(MAX_ROWS))) ? old_cnt + CCW'(1) : old_cnt;
    we      = st.vld && st.pix;
    push    = st.vld && st.res;
    push_data.kind  = st.kind;
    push_data.index = st_idx;
    push_data.count = (st.kind == KIND_COL) ? COUNT_W'(old_cnt) : st_cnt;
  end

  ppc_out_queue u_out_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cnt_o       (q_cnt)
  );

  assign in_ready_o = ({1'b0, q_cnt} + {2'b00, push}) <= 3'(QDEPTH - 1);

  assign pop     = out_valid_o && out_ready_i;
  assign rd_fire = fire && (in_data_i.opcode == OP_READ);

  `PPC_ASSERT(a_queue_bound, q_cnt <= 2'(QDEPTH), "result queue over its depth")
  `PPC_ASSERT_IMPL(a_no_overflow, push && !pop, q_cnt < 2'(QDEPTH), "push into full queue")
  `PPC_ASSERT_NEXT(a_stage_follows, rd_fire, st.vld && st.res, "read word lost before update")
  `PPC_ASSERT_IMPL(a_write_pixel_only, we, st.kind == KIND_ROW, "column write from a read word")

endmodule

### rtl/core/ppc_col_mem.sv
// Column count memory with registered read and write-to-read forwarding
module ppc_col_mem import ppc_pkg::*; #(
  parameter int DEPTH = MAX_COLS_DEF,
  parameter int DW    = COUNT_W
) (
  input  logic                     clk_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [DW-1:0]            rdata_o,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [DW-1:0]            wdata_i
);

  logic [DW-1:0] mem_q [DEPTH];
  logic [DW-1:0] rd_q;
  logic [DW-1:0] fwd_data_q;
  logic          fwd_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rd_q       <= mem_q[raddr_i];
      fwd_q      <= we_i && (waddr_i == raddr_i);
      fwd_data_q <= wdata_i;
    end
  end

  assign rdata_o = fwd_q ? fwd_data_q : rd_q;

endmodule

### rtl/core/ppc_out_queue.sv
// Three-word result queue between the update stage and the output channel
module ppc_out_queue import ppc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  out_word_t   push_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_word_t   out_data_o,
  output logic [1:0]  cnt_o
);

  out_word_t  buf_q [QDEPTH];
  logic [1:0] wr_q, wr_d, rd_q, rd_d, cnt_q, cnt_d;
  logic       pop;

  assign pop = out_valid_o && out_ready_i;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == 2'(QDEPTH - 1)) ? 2'd0 : wr_q + 2'd1;
    end
    if (pop) begin
      rd_d = (rd_q == 2'(QDEPTH - 1)) ? 2'd0 : rd_q + 2'd1;
    end
    if (push_i && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop && !push_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      buf_q[wr_q] <= push_data_i;
    end
  end

  assign out_valid_o = (cnt_q != 2'd0);
  assign out_data_o  = buf_q[rd_q];
  assign cnt_o       = cnt_q;

endmodule

### rtl/core/ppc_frame_ctrl.sv
// Configuration, row and frame state, and the stage that issues column reads
module ppc_frame_ctrl import ppc_pkg::*; #(
  parameter int MAX_COLS = MAX_COLS_DEF,
  parameter int MAX_ROWS = MAX_ROWS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]       cfg_wdata_i,
  input  logic                        fire_i,
  input  in_word_t                    in_data_i,
  output logic                        re_o,
  output logic [$clog2(MAX_COLS)-1:0] raddr_o,
  output stage_t                      st_o,
  output logic [INDEX_W-1:0]          st_idx_o,
  output logic [COUNT_W-1:0]          st_cnt_o,
  output logic [$clog2(MAX_COLS)-1:0] st_addr_o
);

  localparam int AW = $clog2(MAX_COLS);
  localparam int CW = $clog2(MAX_COLS + 1);
  localparam int RW = $clog2(MAX_ROWS);
  localparam int WW = (CW > CFG_DATA_W) ? CW : CFG_DATA_W;
  localparam int XW = (CW > INDEX_W) ? CW : INDEX_W;

  logic [PIXEL_W-1:0]    match_q;
  logic [CFG_DATA_W-1:0] width_q;
  logic [AW-1:0]         pos_q, pos_d;
  logic [CW-1:0]         rcnt_q, rcnt_d;
  logic [RW-1:0]         rnum_q, rnum_d;
  logic [CW-1:0]         hwm_q, hwm_d;
  stage_t                st_q, st_d;
  logic [INDEX_W-1:0]    st_idx_q, st_idx_d;
  logic [COUNT_W-1:0]    st_cnt_q, st_cnt_d;
  logic [AW-1:0]         st_addr_q, st_addr_d;

  logic [WW-1:0] width_x;
  logic [CW-1:0] w_eff;
  logic [CW-1:0] col_next;
  logic [CW-1:0] rcnt_n;
  logic [CW-1:0] row_res;
  logic          hit;
  logic          end_row;

  always_comb begin
    width_x = WW'(width_q);
    if (width_x == '0) begin
      w_eff = CW'(1);
    end else if (width_x > WW'(MAX_COLS)) begin
      w_eff = CW'(MAX_COLS);
    end else begin
      w_eff = CW'(width_x);
    end
    col_next = CW'(pos_q) + CW'(1);
    end_row  = (col_next >= w_eff);
    hit      = (in_data_i.pixel == match_q);
    rcnt_n   = (hit && (rcnt_q < CW'(MAX_COLS))) ? rcnt_q + CW'(1) : rcnt_q;
    row_res  = ({rcnt_n, 1'b0} > {1'b0, w_eff}) ? '0 : rcnt_n;
  end

  always_comb begin
    pos_d     = pos_q;
    rcnt_d    = rcnt_q;
    rnum_d    = rnum_q;
    hwm_d     = hwm_q;
    st_d      = '0;
    st_idx_d  = st_idx_q;
    st_cnt_d  = st_cnt_q;
    st_addr_d = st_addr_q;
    re_o      = 1'b0;
    raddr_o   = pos_q;
    if (fire_i) begin
      case (in_data_i.opcode)
        OP_PIXEL: begin
          re_o         = 1'b1;
          st_d.vld     = 1'b1;
          st_d.pix     = 1'b1;
          st_d.kind    = KIND_ROW;
          st_d.hit     = hit;
          st_d.col_vld = (CW'(pos_q) < hwm_q);
          st_d.res     = end_row;
          st_addr_d    = pos_q;
          st_idx_d     = INDEX_W'(rnum_q);
          st_cnt_d     = COUNT_W'(row_res);
          if (col_next > hwm_q) begin
            hwm_d = col_next;
          end
          if (end_row) begin
            pos_d  = '0;
            rcnt_d = '0;
            if (rnum_q < RW'(MAX_ROWS - 1)) begin
              rnum_d = rnum_q + RW'(1);
            end
          end else begin
            pos_d  = pos_q + AW'(1);
            rcnt_d = rcnt_n;
          end
        end
        OP_READ: begin
          re_o         = 1'b1;
          raddr_o      = AW'(in_data_i.column_index);
          st_d.vld     = 1'b1;
          st_d.res     = 1'b1;
          st_d.kind    = KIND_COL;
          st_d.col_vld = (XW'(in_data_i.column_index) < XW'(hwm_q));
          st_idx_d     = in_data_i.column_index;
          st_addr_d    = AW'(in_data_i.column_index);
        end
        OP_CLEAR: begin
          pos_d  = '0;
          rcnt_d = '0;
          rnum_d = '0;
          hwm_d  = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= MATCH_RST;
      width_q <= WIDTH_RST;
      pos_q   <= '0;
      rcnt_q  <= '0;
      rnum_q  <= '0;
      hwm_q   <= '0;
      st_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_MATCH_VALUE: match_q <= cfg_wdata_i[PIXEL_W-1:0];
          REG_ROW_WIDTH:   width_q <= cfg_wdata_i;
          default: begin
          end
        endcase
      end
      pos_q  <= pos_d;
      rcnt_q <= rcnt_d;
      rnum_q <= rnum_d;
      hwm_q  <= hwm_d;
      st_q   <= st_d;
    end
  end

  always_ff @(posedge clk_i) begin
    st_idx_q  <= st_idx_d;
    st_cnt_q  <= st_cnt_d;
    st_addr_q <= st_addr_d;
  end

  assign st_o      = st_q;
  assign st_idx_o  = st_idx_q;
  assign st_cnt_o  = st_cnt_q;
  assign st_addr_o = st_addr_q;

endmodule

### dv/tb_projection_profile_counter_core.sv
// Testbench for the projection profile counter: random handshakes, predicted row and column counts
`timescale 1ns / 1ps

module tb_projection_profile_counter_core;
  import ppc_pkg::*;

  localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned REPORT_LIMIT = 10;

  class projection_predictor;
    logic [PIXEL_W-1:0]    match_value;
    logic [CFG_DATA_W-1:0] row_width;
    logic [COUNT_W-1:0]    col_count [MAX_COLS_DEF];
    bit                    col_valid [MAX_COLS_DEF];
    logic [INDEX_W-1:0]    col_pos;
    logic [COUNT_W-1:0]    row_count;
    logic [INDEX_W-1:0]    row_num;
    out_word_t             expected_profiles [$];
    int unsigned           mismatch_count;

    function new();
      match_value = MATCH_RST;
      row_width = WIDTH_RST;
      foreach (col_count[i]) col_count[i] = '0;
      foreach (col_valid[i]) col_valid[i] = 1'b0;
      col_pos = '0;
      row_count = '0;
      row_num = '0;
      mismatch_count = 0;
    endfunction

    function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == REG_MATCH_VALUE) match_value = data[PIXEL_W-1:0];
      else if (idx == REG_ROW_WIDTH) row_width = data;
    endfunction

    function void note_word(in_word_t w);
      int        eff_width;
      int        col;
      int        cnt;
      bit        hit;
      out_word_t r;
      case (w.opcode)
        OP_PIXEL: begin
          eff_width = int'(row_width);
          if (eff_width < 1) eff_width = 1;
          if (eff_width > MAX_COLS_DEF) eff_width = MAX_COLS_DEF;
          col = int'(col_pos);
          hit = (w.pixel == match_value);
          cnt = col_valid[col] ? int'(col_count[col]) : 0;
          if (hit && cnt < MAX_ROWS_DEF) cnt++;
          col_count[col] = COUNT_W'(cnt);
          col_valid[col] = 1'b1;
          if (hit && int'(row_count) < MAX_COLS_DEF) row_count++;
          if (col + 1 >= eff_width) begin
            r.kind = KIND_ROW;
            r.index = row_num;
            r.count = (2 * int'(row_count) > eff_width) ? '0 : row_count;
            expected_profiles.push_back(r);
            col_pos = '0;
            row_count = '0;
            if (int'(row_num) < MAX_ROWS_DEF - 1) row_num++;
          end else begin
            col_pos = INDEX_W'(col + 1);
          end
        end
        OP_READ: begin
          r.kind = KIND_COL;
          r.index = w.column_index;
          r.count = col_valid[w.column_index] ? col_count[w.column_index] : '0;
          expected_profiles.push_back(r);
        end
        OP_CLEAR: begin
          foreach (col_valid[i]) col_valid[i] = 1'b0;
          col_pos = '0;
          row_count = '0;
          row_num = '0;
        end
        default: ;
      endcase
    endfunction

    function void flag(string what, out_word_t want, out_word_t got);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT)
        $display("%0t: %s: expected kind %0d index %0d count %0d, got kind %0d index %0d count %0d",
                 $time, what, want.kind, want.index, want.count, got.kind, got.index, got.count);
    endfunction

    function void check_word(out_word_t got);
      out_word_t want;
      if (expected_profiles.size() == 0) begin
        flag("unexpected word", '0, got);
      end else begin
        want = expected_profiles.pop_front();
        if (got.kind !== want.kind || got.index !== want.index || got.count !== want.count)
          flag("wrong word", want, got);
      end
    endfunction

    function int unsigned pending();
      return expected_profiles.size();
    endfunction

    function int unsigned failures();
      return mismatch_count + expected_profiles.size();
    endfunction
  endclass

  logic      clk_i = 1'b0;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_ready_o;
  in_word_t  in_data_i;
  logic      out_valid_o;
  logic      out_ready_i;
  out_word_t out_data_o;
  logic      cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  projection_predictor sb;
  bit          send_quiet;
  bit          recv_quiet;
  bit          hold_off_req;
  int unsigned cycle_count;

  projection_profile_counter_core u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #1 clk_i = ~clk_i;

  function automatic in_word_t pixel_word(logic [PIXEL_W-1:0] px);
    in_word_t w;
    w.opcode = OP_PIXEL;
    w.pixel = px;
    w.column_index = INDEX_W'($urandom);
    return w;
  endfunction

  function automatic in_word_t read_word(logic [INDEX_W-1:0] col);
    in_word_t w;
    w.opcode = OP_READ;
    w.pixel = PIXEL_W'($urandom);
    w.column_index = col;
    return w;
  endfunction

  function automatic in_word_t ctrl_word(logic [OPCODE_W-1:0] op);
    in_word_t w;
    w.opcode = op;
    w.pixel = PIXEL_W'($urandom);
    w.column_index = INDEX_W'($urandom);
    return w;
  endfunction

  // Call at a falling edge; returns at the falling edge after acceptance.
  task automatic push_word(input in_word_t w);
    int unsigned gap;
    if ($urandom_range(0, 39) == 0) send_quiet = !send_quiet;
    gap = send_quiet ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= w;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_word(w);
    @(negedge clk_i);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic set_config(input logic [PIXEL_W-1:0] match_val,
                            input logic [CFG_DATA_W-1:0] width);
    logic [CFG_DATA_W-1:0] match_data;
    match_data = {(CFG_DATA_W - PIXEL_W)'($urandom), match_val};
    cfg_we_i <= 1'b1;
    cfg_idx_i <= REG_MATCH_VALUE;
    cfg_wdata_i <= match_data;
    @(negedge clk_i);
    cfg_idx_i <= REG_ROW_WIDTH;
    cfg_wdata_i <= width;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    sb.write_register(REG_MATCH_VALUE, match_data);
    sb.write_register(REG_ROW_WIDTH, width);
  endtask

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("TB_ERROR");
    $finish;
  end

  initial begin : drain_results
    int unsigned wait_cycles;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if ($urandom_range(0, 39) == 0) recv_quiet = !recv_quiet;
      wait_cycles = recv_quiet ? 0 : $urandom_range(0, 16);
      if (hold_off_req) begin
        wait_cycles = HOLD_CYCLES;
        hold_off_req = 1'b0;
      end
      if (wait_cycles > 0) begin
        out_ready_i <= 1'b0;
        repeat (wait_cycles) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
      sb.check_word(out_data_o);
      @(negedge clk_i);
    end
  end

  initial begin : stimulus
    int                    sel;
    logic [CFG_DATA_W-1:0] width;
    logic [PIXEL_W-1:0]    mv;
    sb = new();
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    out_ready_i = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_wdata_i = '0;
    send_quiet = 1'b0;
    recv_quiet = 1'b0;
    hold_off_req = 1'b0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // partial row at reset settings, then reads and an unused opcode
    for (int n = 0; n < 40; n++)
      push_word(pixel_word(($urandom_range(0, 3) == 0) ? MATCH_RST
                                                         : 8'($urandom_range(0, 254))));
    push_word(read_word(10'd0));
    push_word(read_word(10'd39));
    push_word(read_word(10'd1023));
    push_word(ctrl_word(OP_UNUSED));
    push_word(read_word(10'd40));

    // lower the width below the current position mid-row
    wait_idle();
    set_config(8'h5A, 11'd16);
    push_word(pixel_word(8'h5A));
    push_word(pixel_word(8'h00));
    push_word(pixel_word(8'h5A));
    push_word(read_word(10'd40));
    push_word(read_word(10'd1));

    // oversize width clamps to the column limit, then drop it below the position
    wait_idle();
    set_config(8'hA5, 11'd2047);
    push_word(ctrl_word(OP_CLEAR));
    for (int n = 0; n < 30; n++)
      push_word(pixel_word((n % 2 == 1) ? 8'hA5 : 8'hA5 ^ 8'($urandom_range(1, 255))));
    wait_idle();
    set_config(8'hA5, 11'd10);
    push_word(pixel_word(8'hA5));
    push_word(read_word(10'd0));
    push_word(read_word(10'd30));
    push_word(read_word(10'd31));

    for (int ph = 0; ph < 9; ph++) begin
      wait_idle();
      sel = $urandom_range(0, 9);
      if (ph == 0) width = 11'd0;
      else if (ph == 1) width = 11'd1;
      else width = (sel == 0) ? 11'd0 : (sel == 1) ? 11'd1 : 11'($urandom_range(2, 24));
      sel = $urandom_range(0, 3);
      mv = (sel == 0) ? 8'h00 : (sel == 1) ? 8'hFF : 8'($urandom_range(0, 255));
      set_config(mv, width);
      if (ph == 4) hold_off_req = 1'b1;
      if ($urandom_range(0, 1) == 1) push_word(ctrl_word(OP_CLEAR));
      for (int n = 0; n < 80; n++) begin
        sel = $urandom_range(0, 99);
        if (sel < 70)
          push_word(pixel_word(($urandom_range(0, 1) == 1) ? mv : 8'($urandom_range(0, 255))));
        else if (sel < 86)
          push_word(read_word(($urandom_range(0, 3) == 0) ? 10'($urandom_range(0, 1023))
                                                          : 10'($urandom_range(0, 31))));
        else if (sel < 93)
          push_word(ctrl_word(OP_CLEAR));
        else
          push_word(ctrl_word(OP_UNUSED));
      end
    end
    wait_idle();

    if (sb.failures() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
